[src/verlet_rope_step_unit_assert.svh]
// assertion macros for the verlet rope step unit
// used by the top level only, needs nothing else
`ifndef VERLET_ROPE_STEP_UNIT_ASSERT_SVH
`define VERLET_ROPE_STEP_UNIT_ASSERT_SVH

// same-cycle implication
`define VRS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/vrs_pkg.sv]
// shared types, widths and constants of the verlet rope step unit
// no dependencies
`default_nettype none

package vrs_pkg;

   localparam int DEF_MAX_SEGMENTS = 32;
   localparam int POS_W     = 24;
   localparam int VEC_W     = 3 * POS_W;
   localparam int REQ_W     = 144;
   localparam int RSP_W     = 80;
   localparam int CSR_W     = 18;
   localparam int SQ_W      = 50;
   localparam int ROOT_W    = 25;
   localparam int DIV_NUM_W = 53;
   localparam int DIV_DEN_W = 26;
   localparam int DIV_Q_W   = 27;

   localparam int START_X_I = 38011;
   localparam int START_Y_I = 91750;
   localparam int START_Z_I = 13107;

   localparam logic [16:0]        RST_REACH   = 17'd13107;
   localparam logic [16:0]        RST_REST    = 17'd1966;
   localparam logic [16:0]        RST_LAST    = 17'd13107;
   localparam logic signed [17:0] RST_GRAVITY = -18'sd16384;
   localparam logic [16:0]        RST_VKEEP   = 17'd63570;
   localparam logic [16:0]        RST_SHARE   = 17'd26214;
   localparam logic [5:0]         RST_SEGCNT  = 6'd4;
   localparam logic [4:0]         RST_PASSES  = 5'd15;

   typedef enum logic [2:0] {
      CSR_HANDLE_REACH  = 3'd0,
      CSR_REST_SPACING  = 3'd1,
      CSR_LAST_SPACING  = 3'd2,
      CSR_GRAVITY_FORCE = 3'd3,
      CSR_VELOCITY_KEEP = 3'd4,
      CSR_APPLY_SHARE   = 3'd5,
      CSR_SEGMENT_COUNT = 3'd6,
      CSR_RELAX_PASSES  = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_CLR, ST_IDLE, ST_PREP, ST_ANCH,
      ST_INT_RD, ST_INT_MUL, ST_INT_WR,
      ST_PASS, ST_GAP_RD, ST_GAP_LD, ST_GAP_SQ, ST_ROOT_GO, ST_ROOT,
      ST_ERR, ST_DIV_GO, ST_DIV, ST_SHARE, ST_APPLY, ST_LAST_WR,
      ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

   typedef struct packed {
      logic                 start;
      logic                 neg;
      logic [DIV_NUM_W-1:0] mag;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [DIV_Q_W-1:0] q;
   } div_rsp_type;

   // start column y of segment k with n segments in use
   function automatic logic signed [POS_W-1:0] start_y(input int k, input int n);
      int y;
      y = START_Y_I;
      if (k == 0)
         y = START_Y_I - (n - 2) * int'(RST_REST) - int'(RST_LAST);
      else if (k < n)
         y = START_Y_I - (n - 1 - k) * int'(RST_REST);
      return POS_W'(y);
   endfunction

   function automatic logic [VEC_W-1:0] start_vec(input int k, input int n);
      return {POS_W'(START_Z_I), start_y(k, n), POS_W'(START_X_I)};
   endfunction

endpackage

`default_nettype wire

[src/vrs_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module vrs_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we)
         mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[src/vrs_isqrt.sv]
// floor integer square root, two radicand bits per cycle
// depends on vrs_pkg
`default_nettype none

module vrs_isqrt import vrs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sqrt_req_type req,
   output sqrt_rsp_type rsp
);

   localparam int STEPS = SQ_W / 2;
   localparam int CW    = $clog2(STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [SQ_W-1:0]   val_ff, val_in;
   logic [ROOT_W+2:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+2:0] rem_sh;
   logic [ROOT_W+2:0] trial;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff[ROOT_W:0], val_ff[SQ_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = (rem_sh >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = req.value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in  = {val_ff[SQ_W-3:0], 2'b00};
         rem_in  = ge ? rem_sh - trial : rem_sh;
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

`default_nettype wire

[src/vrs_div.sv]
// bit-serial floor divider for the gap correction, one quotient bit per cycle
// depends on vrs_pkg
`default_nettype none

module vrs_div import vrs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CW = $clog2(DIV_NUM_W);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic                      neg_ff, neg_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0]      mag_ff, mag_in;
   logic [DIV_DEN_W-1:0]      den_ff, den_in;
   logic [DIV_DEN_W:0]        rem_ff, rem_in;
   logic signed [DIV_Q_W-1:0] q_ff, q_in;
   logic [DIV_DEN_W:0]        rem_sh;
   logic                      ge;
   logic [DIV_Q_W-1:0]        q_abs;

   always_comb begin
      rem_sh  = {rem_ff[DIV_DEN_W-1:0], mag_ff[DIV_NUM_W-1]};
      ge      = (rem_sh >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      q_abs   = '0;
      if (req.start) begin
         busy_in = 1'b1;
         neg_in  = req.neg;
         cnt_in  = '0;
         mag_in  = req.mag;
         den_in  = req.den;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         mag_in = {mag_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            // negative numerator rounds away from zero on a remainder
            q_abs = mag_in[DIV_Q_W-1:0] + DIV_Q_W'(neg_ff && (rem_in != '0));
            q_in  = neg_ff ? -$signed(q_abs) : $signed(q_abs);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign rsp.done = done_ff;
   assign rsp.q    = q_ff;

endmodule

`default_nettype wire

[src/verlet_rope_step_unit.sv]
// verlet rope step unit: top level with sequencer, datapath and state memories
// depends on vrs_pkg, vrs_ram, vrs_isqrt, vrs_div, verlet_rope_step_unit_assert.svh
//
// channel  direction  transfer carries
// req_     in         hand position, forward vector, elapsed time (one tick)
// rsp_     out        segment index and position, tlast on the final segment
// csr_     in         register index and write data
//
// after reset a clearing pass over all MAX_SEGMENTS entries lays out the start column
// each gap is set by the bit-serial divider (53 steps) and the root unit (25 steps)
// one tick at a time: req_tready is high only while idle, csr writes are always taken
// rsp_ holds its transfer until rsp_tready, the sequencer waits meanwhile
`default_nettype none

`include "verlet_rope_step_unit_assert.svh"

module verlet_rope_step_unit import vrs_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic             clock,
   input  logic             reset,
   // hand_x, hand_y, hand_z, fwd_x, fwd_y, fwd_z, delta_time, zero pad
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   // seg_index, pos_x, pos_y, pos_z, zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int IDXW  = $clog2(MAX_SEGMENTS);
   localparam int CNTW  = $clog2(MAX_SEGMENTS + 1);
   localparam int RST_N = (MAX_SEGMENTS < 4) ? MAX_SEGMENTS : 4;

   // round a q16 product to nearest, ties up
   function automatic logic signed [31:0] rnd16(input logic signed [47:0] p);
      logic signed [47:0] t;
      t = p + 48'sd32768;
      return $signed(t[47:16]);
   endfunction

   function automatic logic signed [POS_W-1:0] sat24(input logic signed [33:0] v);
      if (v > 34'sd8388607)
         return 24'sh7FFFFF;
      else if (v < -34'sd8388608)
         return 24'sh800000;
      else
         return $signed(v[POS_W-1:0]);
   endfunction

   function automatic logic signed [POS_W-1:0] pos_of(input logic [VEC_W-1:0] v,
                                                      input int a);
      return $signed(v[a*POS_W +: POS_W]);
   endfunction

   // configuration registers
   logic [16:0]        reach_ff, rest_ff, last_ff, vkeep_ff, share_ff;
   logic signed [17:0] grav_ff;
   logic [5:0]         segcnt_ff;
   logic [4:0]         passes_ff;

   // sequencer
   state_type       state_ff, state_in;
   logic [IDXW-1:0] clr_ff, clr_in;
   logic [IDXW-1:0] seg_ff, seg_in;
   logic [IDXW-1:0] gap_ff, gap_in;
   logic [4:0]      pass_ff, pass_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic signed [POS_W-1:0] hand_ff [3];
   logic signed [17:0]      fwd_ff [3];
   logic [15:0]             dt_ff;
   logic signed [35:0]      ap_ff [3];
   logic signed [34:0]      gyp_ff;
   logic signed [POS_W-1:0] anchor_ff [3];
   logic signed [18:0]      gy_ff;
   logic [VEC_W-1:0]        nowv_ff;
   logic signed [42:0]      vp_ff [3];
   logic signed [POS_W-1:0] cur_ff [3];
   logic signed [POS_W-1:0] nxt_ff [3];
   logic signed [24:0]      d_ff [3];
   logic [SQ_W-1:0]         sq_ff [3];
   logic [ROOT_W-1:0]       len_ff;
   logic signed [51:0]      prod_ff [3];
   logic signed [DIV_Q_W-1:0] c_ff [3];
   logic signed [44:0]      pk_ff [3];
   logic signed [44:0]      ps_ff [3];
   logic [RSP_W-1:0]        rsp_data_ff;
   logic                    rsp_last_ff;

   // derived values
   logic [CNTW-1:0]         n_use;
   logic [IDXW-1:0]         last_idx, gap_last;
   logic [16:0]             spacing;
   logic signed [26:0]      err;
   logic signed [17:0]      keep;
   logic signed [POS_W-1:0] int_new [3];
   logic signed [POS_W-1:0] cur_new [3];
   logic signed [POS_W-1:0] nxt_new [3];

   // memory ports
   logic             now_we, old_we;
   logic [IDXW-1:0]  waddr, raddr;
   logic [VEC_W-1:0] now_wdata, old_wdata, now_rdata, old_rdata;

   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;
   div_req_type  div_req [3];
   div_rsp_type  div_rsp [3];
   logic         div_go;

   // clamp the segment count into the supported range
   always_comb begin
      if (int'(segcnt_ff) > MAX_SEGMENTS)
         n_use = CNTW'(MAX_SEGMENTS);
      else if (segcnt_ff < 6'd2)
         n_use = CNTW'(2);
      else
         n_use = CNTW'(segcnt_ff);
      last_idx = IDXW'(n_use - CNTW'(1));
      gap_last = IDXW'(n_use - CNTW'(2));
      spacing  = (gap_ff == gap_last) ? last_ff : rest_ff;
      err      = $signed({2'b00, len_ff}) - $signed({10'd0, spacing});
      keep     = 18'sd65536 - $signed({1'b0, share_ff});
   end

   // position updates
   always_comb begin
      logic signed [POS_W-1:0] t;
      for (int a = 0; a < 3; a++) begin
         t = sat24(34'(pos_of(nowv_ff, a)) + 34'(rnd16(48'(vp_ff[a]))));
         // gravity only acts on y
         if (a == 1)
            t = sat24(34'(t) + 34'(gy_ff));
         int_new[a] = t;
         if (gap_ff == '0) begin
            // first gap: the anchor stays, the second segment takes it all
            cur_new[a] = cur_ff[a];
            nxt_new[a] = sat24(34'(nxt_ff[a]) + 34'(c_ff[a]));
         end else begin
            cur_new[a] = sat24(34'(cur_ff[a]) - 34'(rnd16(48'(pk_ff[a]))));
            nxt_new[a] = sat24(34'(nxt_ff[a]) + 34'(rnd16(48'(ps_ff[a]))));
         end
      end
   end

   // divider operands: floor((2 * d * err + len) / (2 * len))
   always_comb begin
      logic signed [53:0] nsum;
      logic signed [53:0] nabs;
      for (int a = 0; a < 3; a++) begin
         nsum = $signed({prod_ff[a][51], prod_ff[a], 1'b0}) + $signed({29'd0, len_ff});
         nabs = nsum[53] ? -nsum : nsum;
         div_req[a].start = div_go;
         div_req[a].neg   = nsum[53];
         div_req[a].mag   = nabs[DIV_NUM_W-1:0];
         div_req[a].den   = {len_ff, 1'b0};
      end
   end

   // sequencer: next state and memory control
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      seg_in         = seg_ff;
      gap_in         = gap_ff;
      pass_in        = pass_ff;
      rsp_valid_in   = rsp_valid_ff;
      now_we         = 1'b0;
      old_we         = 1'b0;
      waddr          = '0;
      raddr          = '0;
      now_wdata      = '0;
      old_wdata      = '0;
      sqrt_req.start = 1'b0;
      sqrt_req.value = sq_ff[0] + sq_ff[1] + sq_ff[2];
      div_go         = 1'b0;
      unique case (state_ff)
         ST_CLR: begin
            now_we    = 1'b1;
            old_we    = 1'b1;
            waddr     = clr_ff;
            now_wdata = start_vec(int'(clr_ff), RST_N);
            old_wdata = start_vec(int'(clr_ff), RST_N);
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == IDXW'(MAX_SEGMENTS - 1))
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid)
               state_in = ST_PREP;
         end
         ST_PREP: state_in = ST_ANCH;
         ST_ANCH: begin
            seg_in   = IDXW'(1);
            pass_in  = '0;
            state_in = ST_INT_RD;
         end
         ST_INT_RD: begin
            raddr    = seg_ff;
            state_in = ST_INT_MUL;
         end
         ST_INT_MUL: state_in = ST_INT_WR;
         ST_INT_WR: begin
            // old takes the position before the step
            now_we    = 1'b1;
            old_we    = 1'b1;
            waddr     = seg_ff;
            now_wdata = {int_new[2], int_new[1], int_new[0]};
            old_wdata = nowv_ff;
            seg_in    = seg_ff + 1'b1;
            state_in  = (seg_ff == last_idx) ? ST_PASS : ST_INT_RD;
         end
         ST_PASS: begin
            gap_in = '0;
            if (pass_ff == passes_ff) begin
               seg_in   = '0;
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_GAP_RD;
            end
         end
         ST_GAP_RD: begin
            raddr    = IDXW'(gap_ff + 1'b1);
            state_in = ST_GAP_LD;
         end
         ST_GAP_LD: state_in = ST_GAP_SQ;
         ST_GAP_SQ: state_in = ST_ROOT_GO;
         ST_ROOT_GO: begin
            sqrt_req.start = 1'b1;
            state_in       = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_rsp.done)
               state_in = ST_ERR;
         end
         ST_ERR: state_in = ST_DIV_GO;
         ST_DIV_GO: begin
            // a zero-length gap has no direction and no correction
            if (len_ff == '0) begin
               state_in = (gap_ff == '0) ? ST_APPLY : ST_SHARE;
            end else begin
               div_go   = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp[0].done)
               state_in = (gap_ff == '0) ? ST_APPLY : ST_SHARE;
         end
         ST_SHARE: state_in = ST_APPLY;
         ST_APPLY: begin
            // the second segment stays in cur for the next gap
            now_we    = 1'b1;
            waddr     = gap_ff;
            now_wdata = {cur_new[2], cur_new[1], cur_new[0]};
            if (gap_ff == gap_last) begin
               state_in = ST_LAST_WR;
            end else begin
               gap_in   = gap_ff + 1'b1;
               state_in = ST_GAP_RD;
            end
         end
         ST_LAST_WR: begin
            now_we    = 1'b1;
            waddr     = last_idx;
            now_wdata = {cur_ff[2], cur_ff[1], cur_ff[0]};
            pass_in   = pass_ff + 1'b1;
            state_in  = ST_PASS;
         end
         ST_OUT_RD: begin
            raddr    = seg_ff;
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  seg_in   = seg_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         seg_ff       <= '0;
         gap_ff       <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         seg_ff       <= seg_in;
         gap_ff       <= gap_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, loaded by state
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               hand_ff[0] <= $signed(req_tdata[23:0]);
               hand_ff[1] <= $signed(req_tdata[47:24]);
               hand_ff[2] <= $signed(req_tdata[71:48]);
               fwd_ff[0]  <= $signed(req_tdata[89:72]);
               fwd_ff[1]  <= $signed(req_tdata[107:90]);
               fwd_ff[2]  <= $signed(req_tdata[125:108]);
               dt_ff      <= req_tdata[141:126];
            end
         end
         ST_PREP: begin
            for (int a = 0; a < 3; a++)
               ap_ff[a] <= fwd_ff[a] * $signed({1'b0, reach_ff});
            gyp_ff <= grav_ff * $signed({1'b0, dt_ff});
         end
         ST_ANCH: begin
            for (int a = 0; a < 3; a++)
               anchor_ff[a] <= sat24(34'(hand_ff[a]) + 34'(rnd16(48'(ap_ff[a]))));
            gy_ff <= 19'(rnd16(48'(gyp_ff)));
         end
         ST_INT_MUL: begin
            nowv_ff <= now_rdata;
            for (int a = 0; a < 3; a++)
               vp_ff[a] <= (25'(pos_of(now_rdata, a)) - 25'(pos_of(old_rdata, a)))
                           * $signed({1'b0, vkeep_ff});
         end
         ST_PASS: begin
            // each pass pins segment 0 to the anchor
            for (int a = 0; a < 3; a++)
               cur_ff[a] <= anchor_ff[a];
         end
         ST_GAP_LD: begin
            for (int a = 0; a < 3; a++) begin
               nxt_ff[a] <= pos_of(now_rdata, a);
               d_ff[a]   <= 25'(cur_ff[a]) - 25'(pos_of(now_rdata, a));
            end
         end
         ST_GAP_SQ: begin
            for (int a = 0; a < 3; a++)
               sq_ff[a] <= SQ_W'(d_ff[a] * d_ff[a]);
         end
         ST_ROOT: begin
            if (sqrt_rsp.done)
               len_ff <= sqrt_rsp.root;
         end
         ST_ERR: begin
            for (int a = 0; a < 3; a++)
               prod_ff[a] <= d_ff[a] * err;
         end
         ST_DIV_GO: begin
            if (len_ff == '0) begin
               for (int a = 0; a < 3; a++)
                  c_ff[a] <= '0;
            end
         end
         ST_DIV: begin
            if (div_rsp[0].done) begin
               for (int a = 0; a < 3; a++)
                  c_ff[a] <= div_rsp[a].q;
            end
         end
         ST_SHARE: begin
            for (int a = 0; a < 3; a++) begin
               pk_ff[a] <= c_ff[a] * keep;
               ps_ff[a] <= c_ff[a] * $signed({1'b0, share_ff});
            end
         end
         ST_APPLY: begin
            for (int a = 0; a < 3; a++)
               cur_ff[a] <= nxt_new[a];
         end
         ST_OUT_LD: begin
            rsp_data_ff <= {3'b000, now_rdata, 5'(seg_ff)};
            rsp_last_ff <= (seg_ff == last_idx);
         end
         default: begin
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff  <= RST_REACH;
         rest_ff   <= RST_REST;
         last_ff   <= RST_LAST;
         grav_ff   <= RST_GRAVITY;
         vkeep_ff  <= RST_VKEEP;
         share_ff  <= RST_SHARE;
         segcnt_ff <= RST_SEGCNT;
         passes_ff <= RST_PASSES;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_HANDLE_REACH:  reach_ff  <= csr_data[16:0];
            CSR_REST_SPACING:  rest_ff   <= csr_data[16:0];
            CSR_LAST_SPACING:  last_ff   <= csr_data[16:0];
            CSR_GRAVITY_FORCE: grav_ff   <= $signed(csr_data);
            CSR_VELOCITY_KEEP: vkeep_ff  <= csr_data[16:0];
            CSR_APPLY_SHARE:   share_ff  <= csr_data[16:0];
            CSR_SEGMENT_COUNT: segcnt_ff <= csr_data[5:0];
            CSR_RELAX_PASSES:  passes_ff <= csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   // state memories: current and previous positions, {z, y, x}
   vrs_ram #(.WIDTH(VEC_W), .DEPTH(MAX_SEGMENTS)) u_now_ram (
      .clock (clock),
      .we    (now_we),
      .waddr (waddr),
      .wdata (now_wdata),
      .raddr (raddr),
      .rdata (now_rdata)
   );

   vrs_ram #(.WIDTH(VEC_W), .DEPTH(MAX_SEGMENTS)) u_old_ram (
      .clock (clock),
      .we    (old_we),
      .waddr (waddr),
      .wdata (old_wdata),
      .raddr (raddr),
      .rdata (old_rdata)
   );

   vrs_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   // one divider per axis, run in lockstep
   for (genvar g = 0; g < 3; g++) begin : g_div
      vrs_div u_div (
         .clock (clock),
         .reset (reset),
         .req   (div_req[g]),
         .rsp   (div_rsp[g])
      );
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `VRS_ASSERT_NOW(a_div_lockstep, clock, reset, div_rsp[0].done, div_rsp[1].done && div_rsp[2].done, "axis dividers out of step")
   `VRS_ASSERT_NOW(a_no_req_during_rsp, clock, reset, rsp_tvalid, !req_tready, "input taken while a result is pending")
   `VRS_ASSERT_NEXT(a_last_to_idle, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, state_ff == ST_IDLE, "no return to idle after final segment")
   `VRS_ASSERT_NOW(a_no_write_in_output, clock, reset, state_ff == ST_OUT_WAIT, !now_we && !old_we, "memory written during output")

endmodule

`default_nettype wire

[sim/rope_step_checker.sv]
// rope step checker: watches the req_, rsp_ and csr_ channels, keeps its own rope state
// and predicts every segment position of a tick; depends on vrs_pkg only
`timescale 1ns / 1ps

module rope_step_checker import vrs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             rsp_tlast,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  csr_index_type    csr_index,
   input  logic [CSR_W-1:0] csr_data,
   output int               positions_pending,
   output int               error_count
);

   localparam int SEGS = DEF_MAX_SEGMENTS;
   localparam longint ONE = 65536;

   typedef struct {
      logic [4:0]       seg;
      logic [POS_W-1:0] x, y, z;
      logic             last;
   } seg_pos_type;

   seg_pos_type expected_positions[$];

   longint reach, rest, last_gap, gravity, vkeep, share;
   longint seg_cnt, passes;
   longint cur[3][SEGS];
   longint prev[3][SEGS];

   function automatic longint floor_div(input longint n, input longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   // nearest, ties toward +inf
   function automatic longint round_div(input longint n, input longint d);
      return floor_div(2 * n + d, 2 * d);
   endfunction

   function automatic longint clamp_pos(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint root_floor(input longint v);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function void reset_rope();
      longint y;
      reach = 13107; rest = 1966; last_gap = 13107; gravity = -16384;
      vkeep = 63570; share = 26214; seg_cnt = 4; passes = 15;
      for (int k = 0; k < SEGS; k++) begin
         y = START_Y_I;
         if (k == 0) y = START_Y_I - 2 * rest - last_gap;
         else if (k < 4) y = START_Y_I - (3 - k) * rest;
         cur[0][k] = START_X_I; cur[1][k] = y; cur[2][k] = START_Z_I;
         for (int a = 0; a < 3; a++) prev[a][k] = cur[a][k];
      end
   endfunction

   // one pass: pin the anchor, then walk the gaps
   function void relax_pass(input int n, input longint hand[3], input longint fwd[3]);
      longint d[3], c[3];
      longint len, err, keep;
      for (int a = 0; a < 3; a++)
         cur[a][0] = clamp_pos(hand[a] + round_div(fwd[a] * reach, ONE));
      keep = ONE - share;
      for (int i = 0; i < n - 1; i++) begin
         for (int a = 0; a < 3; a++) d[a] = cur[a][i] - cur[a][i + 1];
         len = root_floor(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
         err = len - ((i == n - 2) ? last_gap : rest);
         for (int a = 0; a < 3; a++) c[a] = (len == 0) ? 0 : round_div(d[a] * err, len);
         for (int a = 0; a < 3; a++) begin
            if (i != 0) begin
               cur[a][i] = clamp_pos(cur[a][i] - round_div(c[a] * keep, ONE));
               cur[a][i + 1] = clamp_pos(cur[a][i + 1] + round_div(c[a] * share, ONE));
            end else begin
               cur[a][i + 1] = clamp_pos(cur[a][i + 1] + c[a]);
            end
         end
      end
   endfunction

   function void step_rope(input logic [REQ_W-1:0] t);
      longint hand[3], fwd[3];
      longint dt, gy, v;
      int n;
      seg_pos_type e;
      hand[0] = $signed(t[23:0]);   hand[1] = $signed(t[47:24]); hand[2] = $signed(t[71:48]);
      fwd[0]  = $signed(t[89:72]);  fwd[1]  = $signed(t[107:90]); fwd[2] = $signed(t[125:108]);
      dt = t[141:126];
      gy = round_div(gravity * dt, ONE);
      n = (seg_cnt < 2) ? 2 : (seg_cnt > SEGS) ? SEGS : int'(seg_cnt);
      // damped verlet on every segment but the anchor
      for (int i = 1; i < n; i++) begin
         for (int a = 0; a < 3; a++) begin
            v = cur[a][i] - prev[a][i];
            prev[a][i] = cur[a][i];
            cur[a][i] = clamp_pos(cur[a][i] + round_div(v * vkeep, ONE));
         end
         cur[1][i] = clamp_pos(cur[1][i] + gy);
      end
      for (longint p = 0; p < passes; p++) relax_pass(n, hand, fwd);
      for (int i = 0; i < n; i++) begin
         e.seg = 5'(i);
         e.x = POS_W'(cur[0][i]); e.y = POS_W'(cur[1][i]); e.z = POS_W'(cur[2][i]);
         e.last = (i == n - 1);
         expected_positions.insert(expected_positions.size(), e);
      end
   endfunction

   initial begin
      error_count = 0;
      positions_pending = 0;
   end

   always @(posedge clock) begin
      seg_pos_type e;
      if (reset) begin
         reset_rope();
         expected_positions.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HANDLE_REACH:  reach    = csr_data[16:0];
               CSR_REST_SPACING:  rest     = csr_data[16:0];
               CSR_LAST_SPACING:  last_gap = csr_data[16:0];
               CSR_GRAVITY_FORCE: gravity  = $signed(csr_data[17:0]);
               CSR_VELOCITY_KEEP: vkeep    = csr_data[16:0];
               CSR_APPLY_SHARE:   share    = csr_data[16:0];
               CSR_SEGMENT_COUNT: seg_cnt  = csr_data[5:0];
               CSR_RELAX_PASSES:  passes   = csr_data[4:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) step_rope(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_positions.size() == 0) begin
               $error("position transfer with nothing expected: %h", rsp_tdata);
               error_count++;
            end else begin
               e = expected_positions.pop_front();
               if (rsp_tdata[4:0] !== e.seg) begin
                  $error("seg_index expected %0d got %0d", e.seg, rsp_tdata[4:0]);
                  error_count++;
               end
               if (rsp_tdata[28:5] !== e.x) begin
                  $error("pos_x expected %h got %h", e.x, rsp_tdata[28:5]);
                  error_count++;
               end
               if (rsp_tdata[52:29] !== e.y) begin
                  $error("pos_y expected %h got %h", e.y, rsp_tdata[52:29]);
                  error_count++;
               end
               if (rsp_tdata[76:53] !== e.z) begin
                  $error("pos_z expected %h got %h", e.z, rsp_tdata[76:53]);
                  error_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_seg expected %0d got %0d", e.last, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
      positions_pending = expected_positions.size();
   end

endmodule

[sim/testbench.sv]
// top of the rope step bench: clock, reset, tick and register stimulus, verdict
// depends on vrs_pkg, verlet_rope_step_unit and rope_step_checker
`timescale 1ns / 1ps

module testbench;
   import vrs_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   csr_index_type    csr_index = CSR_HANDLE_REACH;
   logic [CSR_W-1:0] csr_data = '0;

   int positions_pending;
   int error_count;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;

   // generous idle time before a register write, the block may still be finishing
   localparam int SETTLE_CYCLES = 64;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   verlet_rope_step_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   rope_step_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .positions_pending(positions_pending), .error_count(error_count)
   );

   // receiver stall, redrawn every cycle
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);

   // hard stop well past the slowest correct run
   initial begin
      #100_000_000;
      $display("testbench: errors");
      $finish;
   end

   function automatic logic [REQ_W-1:0] pack_tick(
      input logic [23:0] hx, input logic [23:0] hy, input logic [23:0] hz,
      input logic [17:0] fx, input logic [17:0] fy, input logic [17:0] fz,
      input logic [15:0] dt);
      return {2'b00, dt, fz, fy, fx, hz, hy, hx};
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_tick(input logic [REQ_W-1:0] t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = t;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (positions_pending != 0) @(negedge clock);
   endtask

   // registers are written only with the block idle
   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] val);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all(input logic [CSR_W-1:0] reach, input logic [CSR_W-1:0] rest,
                            input logic [CSR_W-1:0] lastg, input logic [CSR_W-1:0] grav,
                            input logic [CSR_W-1:0] vk, input logic [CSR_W-1:0] sh,
                            input logic [CSR_W-1:0] cnt, input logic [CSR_W-1:0] np);
      write_reg(CSR_HANDLE_REACH, reach);
      write_reg(CSR_REST_SPACING, rest);
      write_reg(CSR_LAST_SPACING, lastg);
      write_reg(CSR_GRAVITY_FORCE, grav);
      write_reg(CSR_VELOCITY_KEEP, vk);
      write_reg(CSR_APPLY_SHARE, sh);
      write_reg(CSR_SEGMENT_COUNT, cnt);
      write_reg(CSR_RELAX_PASSES, np);
   endtask

   // hand mostly near the origin so the rope stays sane, sometimes anywhere
   task automatic random_tick();
      logic [23:0] h[3];
      logic [17:0] f[3];
      for (int a = 0; a < 3; a++) begin
         h[a] = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($signed($urandom_range(0, 262143)) - 131072);
         case ($urandom_range(3))
            0: f[a] = 18'($urandom);
            1: f[a] = 18'sd65536;
            2: f[a] = -18'sd65536;
            default: f[a] = 18'($signed($urandom_range(0, 131072)) - 65536);
         endcase
      end
      send_tick(pack_tick(h[0], h[1], h[2], f[0], f[1], f[2], 16'($urandom)));
   endtask

   initial begin
      logic [5:0] cnt;
      logic [4:0] np;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes of every field with the reset register values
      send_tick(pack_tick(24'd70000, 24'd90000, 24'd10000, 18'd0, 18'sd65536, 18'd0, 16'd1092));
      send_tick(pack_tick(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                          18'sd65536, 18'sd65536, 18'sd65536, 16'hFFFF));
      send_tick(pack_tick(24'h800000, 24'h800000, 24'h800000,
                          -18'sd65536, -18'sd65536, -18'sd65536, 16'h0000));
      send_tick(pack_tick(24'd0, 24'd0, 24'd0, 18'h1FFFF, 18'h20000, 18'h3FFFF, 16'h8000));
      send_tick(pack_tick(24'hFFFFFF, 24'h000001, 24'h555555,
                          18'h20000, 18'h1FFFF, 18'h2AAAA, 16'h5555));

      // no relaxation pass: anchor keeps its place
      write_reg(CSR_SEGMENT_COUNT, 18'd6);
      write_reg(CSR_RELAX_PASSES, 18'd0);
      send_tick(pack_tick(24'd1000, 24'd2000, 24'd3000, 18'd0, 18'd0, 18'sd65536, 16'd2000));
      // new segments all sit on the start point: zero-length gaps
      write_reg(CSR_RELAX_PASSES, 18'd3);
      send_tick(pack_tick(24'd0, 24'd100000, 24'd0, 18'd0, 18'd0, 18'd0, 16'd0));
      send_tick(pack_tick(24'd500, 24'd90000, 24'd200, 18'sd65536, 18'd0, 18'd0, 16'd1092));

      // all registers at the top but two relaxation passes, count above range, share above one
      write_all(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
                18'd63, 18'd2);
      send_tick(pack_tick(24'd0, 24'd0, 24'd0, 18'sd65536, 18'd0, 18'd0, 16'hFFFF));
      send_tick(pack_tick(24'h7FFFFF, 24'h800000, 24'd0, 18'd0, -18'sd65536, 18'd0, 16'd100));

      // all at the bottom but one relaxation pass, count below range
      write_all(18'd0, 18'd0, 18'd0, 18'h20000, 18'd0, 18'd0, 18'd0, 18'd1);
      send_tick(pack_tick(24'd0, 24'd0, 24'd0, 18'd0, 18'd0, 18'd0, 16'hFFFF));
      send_tick(pack_tick(24'h123456, 24'hFEDCBA, 24'd77, 18'sd65536, 18'sd65536, 18'd0, 16'd1));
      write_reg(CSR_SEGMENT_COUNT, 18'd1);
      send_tick(pack_tick(24'd10, 24'd20, 24'd30, 18'd0, 18'd0, -18'sd65536, 16'd999));

      // one full-size tick: every segment, most passes, share exactly one
      write_all(18'd13107, 18'd1966, 18'd13107, 18'sd65536, 18'd63570, 18'd65536,
                18'd32, 18'd31);
      send_tick(pack_tick(24'd38011, 24'd91750, 24'd13107, 18'd0, 18'd0, 18'sd65536, 16'd1092));

      // random part, idling mode changes every third of the phases
      for (int ph = 0; ph < 12; ph++) begin
         if (ph < 4) begin
            sender_idle_pct = 31; receiver_idle_pct = 73;
         end else if (ph < 8) begin
            sender_idle_pct = 73; receiver_idle_pct = 31;
         end else begin
            sender_idle_pct = 0; receiver_idle_pct = 0;
         end
         // mostly short ropes; long ropes or many passes only one at a time
         cnt = ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8));
         if (cnt > 8) np = 5'($urandom_range(0, 3));
         else if (cnt <= 4 && $urandom_range(3) == 0) np = 5'($urandom);
         else np = 5'($urandom_range(0, 6));
         write_all(18'($urandom_range(0, 131071)), 18'($urandom_range(0, 131071)),
                   18'($urandom_range(0, 131071)), 18'($urandom),
                   18'($urandom_range(0, 131071)), 18'($urandom_range(0, 131071)),
                   18'(cnt), 18'(np));
         for (int k = 0; k < 10; k++) begin
            // sender holds off until the rope has reported everything
            if (ph == 5 && k == 5) drain();
            random_tick();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
